@@ design/iomt_pkg.sv @@
// iomt_pkg: shared types, register indexes, write masks and codes for the
// I/O MMU register and translate block. No dependencies.
package iomt_pkg;

  // sizes
  localparam int REG_WORDS_DEF = 4096;
  localparam int IDX_W         = 12;
  localparam int Q_DEPTH       = 2;
  localparam int OUT_DEPTH     = 4;
  localparam int OUT_LVL_W     = $clog2(OUT_DEPTH + 1);

  // transaction modes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_XLATE = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // register classes found by the front end
  localparam logic [3:0] CL_CTRL   = 4'd0;
  localparam logic [3:0] CL_BASE   = 4'd1;
  localparam logic [3:0] CL_FSR    = 4'd2;
  localparam logic [3:0] CL_FAR    = 4'd3;
  localparam logic [3:0] CL_AER    = 4'd4;
  localparam logic [3:0] CL_SBC    = 4'd5;
  localparam logic [3:0] CL_ARBEN  = 4'd6;
  localparam logic [3:0] CL_MASKID = 4'd7;
  localparam logic [3:0] CL_PLAIN  = 4'd8;
  localparam logic [3:0] CL_BEYOND = 4'd9;

  // register word indexes
  localparam logic [IDX_W-1:0] IX_CTRL   = 12'h000;
  localparam logic [IDX_W-1:0] IX_BASE   = 12'h001;
  localparam logic [IDX_W-1:0] IX_FSR    = 12'h400;
  localparam logic [IDX_W-1:0] IX_FAR    = 12'h401;
  localparam logic [IDX_W-1:0] IX_AER    = 12'h402;
  localparam logic [IDX_W-1:0] IX_SBC0   = 12'h404;
  localparam logic [IDX_W-1:0] IX_SBC3   = 12'h407;
  localparam logic [IDX_W-1:0] IX_ARBEN  = 12'h800;
  localparam logic [IDX_W-1:0] IX_MASKID = 12'hc06;

  // write masks and forced bits
  localparam logic [31:0] MSK_CTRL    = 32'h0000001d;
  localparam logic [31:0] MSK_BASE    = 32'h07fffc00;
  localparam logic [31:0] MSK_FSR     = 32'hff0fffff;
  localparam logic [31:0] SET_FSR     = 32'h00800000;
  localparam logic [31:0] MSK_AER     = 32'h801f000f;
  localparam logic [31:0] SET_AER     = 32'h00000001;
  localparam logic [31:0] MSK_SBC     = 32'h00010003;
  localparam logic [31:0] MSK_ARBEN   = 32'h001f0000;
  localparam logic [31:0] SET_ARBEN   = 32'h00000008;
  localparam logic [31:0] MSK_MASKID  = 32'h00ffffff;
  localparam logic [31:0] WIN_BASE    = 32'hff000000;

  // reset values
  localparam logic [31:0] RST_FSR    = 32'h00800000;
  localparam logic [31:0] RST_AER    = 32'h00000003;
  localparam logic [31:0] RST_ARBEN  = 32'h00000008;
  localparam logic [31:0] RST_MASKID = 32'h23000000;

  // fault status words
  localparam logic [31:0] FSR_FAULT = 32'hc0820000;
  localparam logic [31:0] FSR_RDBIT = 32'h00040000;

  // permission codes
  localparam logic [1:0] PERM_NONE = 2'd0;
  localparam logic [1:0] PERM_RO   = 2'd1;
  localparam logic [1:0] PERM_RW   = 2'd2;

  // classified transaction between front and back
  typedef struct packed {
    logic [1:0]       op;
    logic [3:0]       cls;
    logic [IDX_W-1:0] idx;
    logic [31:0]      wval;
    logic [2:0]       code;
    logic [31:0]      page;
    logic [35:0]      pa;
    logic [1:0]       perm;
    logic             flt;
  } item_t;

  // result transaction
  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] pte_address;
    logic [35:0] phys_address;
    logic [31:0] page_address;
    logic [1:0]  permission;
    logic        fault;
    logic        interrupt_out;
  } res_t;

  // back end status toward the top level
  typedef struct packed {
    logic init_busy;
    logic res_push;
  } bk_stat_t;

endpackage

@@ design/iomt_ram.sv @@
// iomt_ram: generic single-port RAM with registered read data.
// No dependencies.
module iomt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and read-first registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/iomt_fifo.sv @@
// iomt_fifo: small register-based queue with occupancy count.
// No dependencies.
module iomt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic [WIDTH-1:0]               wr_data,
  input  logic                           pop,
  output logic [WIDTH-1:0]               rd_data,
  output logic                           full,
  output logic                           empty,
  output logic [$clog2(DEPTH+1)-1:0]     level
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [LW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == LW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign level   = cnt_r;
  assign rd_data = mem_r[rp_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  // pointer and count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + LW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

@@ design/iomt_front.sv @@
// iomt_front: accepts transactions, classifies the register index and
// precomputes write values and translation fields. Uses iomt_pkg.
module iomt_front import iomt_pkg::*; #(
  parameter int REG_WORDS = REG_WORDS_DEF
) (
  input  logic             push,
  output logic             full,
  input  logic             q_full,
  input  logic             init_busy,
  input  logic [1:0]       in_mode,
  input  logic [IDX_W-1:0] in_reg_index,
  input  logic [31:0]      in_write_data,
  input  logic [31:0]      in_dvma_address,
  input  logic             in_access_is_write,
  input  logic [31:0]      in_pte_word,
  output logic             q_push,
  output item_t            q_item
);

  localparam logic [IDX_W:0] LIMIT = (IDX_W + 1)'(REG_WORDS);

  logic [3:0]  cls;
  logic [31:0] v;
  logic [31:0] wval;

  assign full   = q_full | init_busy;
  assign q_push = push & ~full;
  assign v      = in_write_data;

  // index classification
  always_comb begin
    priority if ({1'b0, in_reg_index} >= LIMIT) begin
      cls = CL_BEYOND;
    end else if (in_reg_index == IX_CTRL) begin
      cls = CL_CTRL;
    end else if (in_reg_index == IX_BASE) begin
      cls = CL_BASE;
    end else if (in_reg_index == IX_FSR) begin
      cls = CL_FSR;
    end else if (in_reg_index == IX_FAR) begin
      cls = CL_FAR;
    end else if (in_reg_index == IX_AER) begin
      cls = CL_AER;
    end else if (in_reg_index >= IX_SBC0 && in_reg_index <= IX_SBC3) begin
      cls = CL_SBC;
    end else if (in_reg_index == IX_ARBEN) begin
      cls = CL_ARBEN;
    end else if (in_reg_index == IX_MASKID) begin
      cls = CL_MASKID;
    end else begin
      cls = CL_PLAIN;
    end
  end

  // masked write value, or the fault status word for a translation
  always_comb begin
    wval = v;
    if (in_mode == OP_XLATE) begin
      wval = FSR_FAULT | (in_access_is_write ? 32'h0 : FSR_RDBIT);
    end else begin
      unique case (cls)
        CL_CTRL:   wval = v & MSK_CTRL;
        CL_BASE:   wval = v & MSK_BASE;
        CL_FSR:    wval = (v & MSK_FSR) | SET_FSR;
        CL_AER:    wval = (v & MSK_AER) | SET_AER;
        CL_SBC:    wval = v & MSK_SBC;
        CL_ARBEN:  wval = (v & MSK_ARBEN) | SET_ARBEN;
        CL_MASKID: wval = v & MSK_MASKID;
        default:   wval = v;
      endcase
    end
  end

  // classified transaction
  always_comb begin
    q_item      = '0;
    q_item.op   = in_mode;
    q_item.cls  = cls;
    q_item.idx  = in_reg_index;
    q_item.wval = wval;
    q_item.code = in_write_data[4:2];
    q_item.page = {in_dvma_address[31:12], 12'h000};
    q_item.pa   = {in_pte_word[31:8], in_dvma_address[11:0]};
    q_item.perm = in_pte_word[2] ? PERM_RW : PERM_RO;
    q_item.flt  = ~in_pte_word[1] | (in_access_is_write & ~in_pte_word[2]);
  end

endmodule

@@ design/iomt_back.sv @@
// iomt_back: executes classified transactions in order against the register
// store (RAM plus named registers) and builds results. Uses iomt_pkg, iomt_ram.
module iomt_back import iomt_pkg::*; #(
  parameter int REG_WORDS = REG_WORDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata,
  input  logic                 q_empty,
  input  item_t                q_item,
  output logic                 q_pop,
  input  logic [OUT_LVL_W-1:0] out_level,
  output res_t                 res_data,
  output bk_stat_t             stat
);

  localparam int AW = $clog2(REG_WORDS);

  // state
  logic [31:0]   version_r;
  logic [31:0]   base_r, base_nxt;
  logic [31:0]   fsr_r, fsr_nxt;
  logic [31:0]   far_r, far_nxt;
  logic [31:0]   aer_r, aer_nxt;
  logic [31:0]   arben_r, arben_nxt;
  logic [31:0]   maskid_r, maskid_nxt;
  logic [31:0]   window_r, window_nxt;
  logic          irq_r, irq_nxt;
  logic          busy_r;
  logic [AW-1:0] clr_cnt_r;

  // result stage
  logic          r_valid_r;
  logic          r_use_ram_r;
  res_t          r_res_r;

  logic          exec, room, ram_cls, use_ram;
  logic [OUT_LVL_W:0] lvl_sum;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_wdata, ram_rdata;
  logic [31:0]   off;
  res_t          res;
  item_t         it;

  assign it      = q_item;
  assign lvl_sum = (OUT_LVL_W + 1)'(out_level) + (OUT_LVL_W + 1)'(r_valid_r);
  assign room    = lvl_sum < (OUT_LVL_W + 1)'(OUT_DEPTH);
  assign exec    = ~q_empty & ~busy_r & room;
  assign q_pop   = exec;
  assign ram_cls = (it.cls == CL_CTRL) | (it.cls == CL_SBC) | (it.cls == CL_PLAIN);
  assign off     = ((it.page & ~window_r) >> 10) & ~32'd3;

  // execute one transaction, or clear a store word during the clearing pass
  always_comb begin
    base_nxt   = base_r;
    fsr_nxt    = fsr_r;
    far_nxt    = far_r;
    aer_nxt    = aer_r;
    arben_nxt  = arben_r;
    maskid_nxt = maskid_r;
    window_nxt = window_r;
    irq_nxt    = irq_r;
    res        = '0;
    use_ram    = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = it.idx[AW-1:0];
    ram_wdata  = it.wval;
    if (busy_r) begin
      ram_we    = 1'b1;
      ram_addr  = clr_cnt_r;
      ram_wdata = '0;
    end else if (exec) begin
      unique case (it.op)
        OP_READ: begin
          unique case (it.cls)
            CL_BASE:   res.read_data = base_r;
            CL_FSR:    res.read_data = fsr_r;
            CL_FAR:    res.read_data = far_r;
            CL_AER:    res.read_data = aer_r;
            CL_ARBEN:  res.read_data = arben_r;
            CL_MASKID: res.read_data = maskid_r;
            CL_CTRL, CL_SBC, CL_PLAIN: use_ram = 1'b1;
            default:   res.read_data = '0;
          endcase
          if (it.cls == CL_FSR || it.cls == CL_FAR) begin
            irq_nxt = 1'b0;
          end
        end
        OP_WRITE: begin
          ram_we = ram_cls;
          unique case (it.cls)
            CL_CTRL: begin
              window_nxt = WIN_BASE << it.code;
              ram_wdata  = it.wval | version_r;
            end
            CL_BASE:   base_nxt = it.wval;
            CL_FSR: begin
              fsr_nxt = it.wval;
              irq_nxt = 1'b0;
            end
            CL_FAR: begin
              far_nxt = it.wval;
              irq_nxt = 1'b0;
            end
            CL_AER:    aer_nxt    = it.wval;
            CL_ARBEN:  arben_nxt  = it.wval;
            CL_MASKID: maskid_nxt = maskid_r | it.wval;
            default:   ram_wdata  = it.wval;
          endcase
        end
        OP_XLATE: begin
          res.pte_address = {base_r[27:0], 4'h0} + off;
          if (it.flt) begin
            fsr_nxt   = it.wval;
            far_nxt   = it.page;
            irq_nxt   = 1'b1;
            res.fault = 1'b1;
          end else begin
            res.phys_address = it.pa;
            res.page_address = it.page;
            res.permission   = it.perm;
          end
        end
        default: ;
      endcase
      res.interrupt_out = irq_nxt;
    end
  end

  // architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= '0;
      base_r    <= '0;
      fsr_r     <= RST_FSR;
      far_r     <= '0;
      aer_r     <= RST_AER;
      arben_r   <= RST_ARBEN;
      maskid_r  <= RST_MASKID;
      window_r  <= '0;
      irq_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        version_r <= cfg_wdata;
      end
      base_r   <= base_nxt;
      fsr_r    <= fsr_nxt;
      far_r    <= far_nxt;
      aer_r    <= aer_nxt;
      arben_r  <= arben_nxt;
      maskid_r <= maskid_nxt;
      window_r <= window_nxt;
      irq_r    <= irq_nxt;
    end
  end

  // clearing pass over the store after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else if (busy_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(REG_WORDS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // result stage, registered alongside the store's registered read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_valid_r <= 1'b0;
    end else begin
      r_valid_r <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      r_res_r     <= res;
      r_use_ram_r <= use_ram;
    end
  end

  iomt_ram #(
    .WIDTH (32),
    .DEPTH (REG_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // merge store data into the result
  always_comb begin
    res_data = r_res_r;
    if (r_use_ram_r) begin
      res_data.read_data = ram_rdata;
    end
  end

  assign stat.init_busy = busy_r;
  assign stat.res_push  = r_valid_r;

endmodule

@@ design/io_mmu_register_and_translate.sv @@
// io_mmu_register_and_translate: top level; front end, transaction queue,
// back end and result queue. Uses iomt_pkg, iomt_front, iomt_fifo, iomt_back.
// Path of a transaction: transaction queue, result stage, result queue.
// Throughput: one transaction per cycle, set by the single store RAM port and
// the back end, while no clearing pass runs and the result queue has room.
// Reset: synchronous active-low; afterwards a clearing pass over every store
// word zeroes the register store, with full held high; cfg writes accepted.
module io_mmu_register_and_translate import iomt_pkg::*; #(
  parameter int REG_WORDS = REG_WORDS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // configuration
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [31:0]      cfg_data,
  // input queue side
  input  logic             push,
  output logic             full,
  input  logic [1:0]       in_mode,
  input  logic [IDX_W-1:0] in_reg_index,
  input  logic [31:0]      in_write_data,
  input  logic [31:0]      in_dvma_address,
  input  logic             in_access_is_write,
  input  logic [31:0]      in_pte_word,
  // result queue side
  output logic             empty,
  input  logic             pop,
  output logic [31:0]      out_read_data,
  output logic [31:0]      out_pte_address,
  output logic [35:0]      out_phys_address,
  output logic [31:0]      out_page_address,
  output logic [1:0]       out_permission,
  output logic             out_fault,
  output logic             out_interrupt_out
);

  logic               q_push, q_pop, q_full, q_empty;
  logic [$bits(item_t)-1:0] q_rd_bits;
  logic [$clog2(Q_DEPTH+1)-1:0] q_level;
  item_t              q_din, q_dout;
  logic               o_full;
  logic [OUT_LVL_W-1:0] o_level;
  logic [$bits(res_t)-1:0] o_rd_bits;
  res_t               res_in, res_out;
  bk_stat_t           stat;

  assign cfg_ready = 1'b1;

  iomt_front #(
    .REG_WORDS (REG_WORDS)
  ) u_front (
    .push               (push),
    .full               (full),
    .q_full             (q_full),
    .init_busy          (stat.init_busy),
    .in_mode            (in_mode),
    .in_reg_index       (in_reg_index),
    .in_write_data      (in_write_data),
    .in_dvma_address    (in_dvma_address),
    .in_access_is_write (in_access_is_write),
    .in_pte_word        (in_pte_word),
    .q_push             (q_push),
    .q_item             (q_din)
  );

  // queue between front and back
  iomt_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_din),
    .pop     (q_pop),
    .rd_data (q_rd_bits),
    .full    (q_full),
    .empty   (q_empty),
    .level   (q_level)
  );

  assign q_dout = item_t'(q_rd_bits);

  iomt_back #(
    .REG_WORDS (REG_WORDS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_wdata (cfg_data),
    .q_empty   (q_empty),
    .q_item    (q_dout),
    .q_pop     (q_pop),
    .out_level (o_level),
    .res_data  (res_in),
    .stat      (stat)
  );

  // result queue
  iomt_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (stat.res_push),
    .wr_data (res_in),
    .pop     (pop),
    .rd_data (o_rd_bits),
    .full    (o_full),
    .empty   (empty),
    .level   (o_level)
  );

  assign res_out           = res_t'(o_rd_bits);
  assign out_read_data     = res_out.read_data;
  assign out_pte_address   = res_out.pte_address;
  assign out_phys_address  = res_out.phys_address;
  assign out_page_address  = res_out.page_address;
  assign out_permission    = res_out.permission;
  assign out_fault         = res_out.fault;
  assign out_interrupt_out = res_out.interrupt_out;

  // result queue space is reserved before execution
  a_no_outq_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.res_push |-> !o_full)
    else $error("result queue overflow");

  // front queue never overruns, also while the store is being cleared
  a_no_q_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (!q_full && !stat.init_busy && q_level != Q_DEPTH[$clog2(Q_DEPTH+1)-1:0]))
    else $error("transaction queue overflow");

  // a faulting translation leaves the interrupt raised
  a_fault_irq: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_fault) |-> out_interrupt_out)
    else $error("fault without interrupt");

  // a faulting translation reports no mapping
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_fault) |->
      (out_phys_address == '0 && out_page_address == '0 && out_permission == PERM_NONE))
    else $error("fault with mapping fields set");

endmodule

@@ tb/iomt_xlate_monitor.sv @@
// iomt_xlate_monitor: watches the config, input and result channels of the
// I/O MMU register and translate block, predicts each result and compares.
// Depends on iomt_pkg for the result struct, mode codes and register indexes.
`timescale 1ns / 100ps

module iomt_xlate_monitor import iomt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [31:0]      cfg_data,
  input  logic             push,
  input  logic             full,
  input  logic [1:0]       in_mode,
  input  logic [IDX_W-1:0] in_reg_index,
  input  logic [31:0]      in_write_data,
  input  logic [31:0]      in_dvma_address,
  input  logic             in_access_is_write,
  input  logic [31:0]      in_pte_word,
  input  logic             empty,
  input  logic             pop,
  input  logic [31:0]      out_read_data,
  input  logic [31:0]      out_pte_address,
  input  logic [35:0]      out_phys_address,
  input  logic [31:0]      out_page_address,
  input  logic [1:0]       out_permission,
  input  logic             out_fault,
  input  logic             out_interrupt_out,
  output int               fail_count,
  output int               pending_count
);

  // write masks, forced bits and fault words, kept apart from the package
  localparam logic [31:0] CTRL_KEEP   = 32'h0000001d;
  localparam logic [31:0] BASE_KEEP   = 32'h07fffc00;
  localparam logic [31:0] FSR_KEEP    = 32'hff0fffff;
  localparam logic [31:0] FSR_FORCE   = 32'h00800000;
  localparam logic [31:0] AER_KEEP    = 32'h801f000f;
  localparam logic [31:0] SBC_KEEP    = 32'h00010003;
  localparam logic [31:0] ARBEN_KEEP  = 32'h001f0000;
  localparam logic [31:0] ARBEN_FORCE = 32'h00000008;
  localparam logic [31:0] MASKID_KEEP = 32'h00ffffff;
  localparam logic [31:0] WINDOW_TOP  = 32'hff000000;
  localparam logic [31:0] FAULT_WORD  = 32'hc0820000;
  localparam logic [31:0] FAULT_READ  = 32'h00040000;

  logic [31:0] reg_file [0:REG_WORDS_DEF-1];
  logic [31:0] version_bits;
  logic [31:0] win_start;
  logic        irq_level;
  res_t        expected_results [$];

  // state after reset
  function automatic void clear_state();
    for (int i = 0; i < REG_WORDS_DEF; i++) reg_file[i] = '0;
    reg_file[IX_FSR]    = 32'h00800000;
    reg_file[IX_AER]    = 32'h00000003;
    reg_file[IX_ARBEN]  = 32'h00000008;
    reg_file[IX_MASKID] = 32'h23000000;
    version_bits = '0;
    win_start    = '0;
    irq_level    = 1'b0;
  endfunction

  // register write with per-register masks and side effects
  function automatic void store_word(logic [IDX_W-1:0] ix, logic [31:0] v);
    if (ix == IX_CTRL) begin
      win_start    = WINDOW_TOP << v[4:2];
      reg_file[ix] = (v & CTRL_KEEP) | version_bits;
    end else if (ix == IX_BASE) begin
      reg_file[ix] = v & BASE_KEEP;
    end else if (ix == IX_FAR) begin
      reg_file[ix] = v;
      irq_level    = 1'b0;
    end else if (ix == IX_FSR) begin
      reg_file[ix] = (v & FSR_KEEP) | FSR_FORCE;
      irq_level    = 1'b0;
    end else if (ix == IX_AER) begin
      reg_file[ix] = (v & AER_KEEP) | 32'h1;
    end else if (ix >= IX_SBC0 && ix <= IX_SBC3) begin
      reg_file[ix] = v & SBC_KEEP;
    end else if (ix == IX_ARBEN) begin
      reg_file[ix] = (v & ARBEN_KEEP) | ARBEN_FORCE;
    end else if (ix == IX_MASKID) begin
      reg_file[ix] = reg_file[ix] | (v & MASKID_KEEP);
    end else begin
      reg_file[ix] = v;
    end
  endfunction

  // one accepted transaction: update state, return the expected result
  function automatic res_t mmu_step(logic [1:0] mode, logic [IDX_W-1:0] ix,
                                    logic [31:0] wd, logic [31:0] dv, logic wr,
                                    logic [31:0] pte);
    res_t        r;
    logic [31:0] page;
    logic [31:0] offs;
    r = '0;
    case (mode)
      OP_READ: begin
        r.read_data = reg_file[ix];
        if (ix == IX_FSR || ix == IX_FAR) irq_level = 1'b0;
      end
      OP_WRITE: store_word(ix, wd);
      OP_XLATE: begin
        page = dv & 32'hfffff000;
        offs = ((page & ~win_start) >> 10) & ~32'd3;
        r.pte_address = {reg_file[IX_BASE][27:0], 4'h0} + offs;
        if (!pte[1] || (wr && !pte[2])) begin
          reg_file[IX_FSR] = wr ? FAULT_WORD : (FAULT_WORD | FAULT_READ);
          reg_file[IX_FAR] = page;
          irq_level        = 1'b1;
          r.fault          = 1'b1;
        end else begin
          r.phys_address = {pte[31:8], dv[11:0]};
          r.page_address = page;
          r.permission   = pte[2] ? PERM_RW : PERM_RO;
        end
      end
      default: ;
    endcase
    r.interrupt_out = irq_level;
    return r;
  endfunction

  function automatic void check_field(string name, logic [35:0] want, logic [35:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // sample all three channels at the rising edge
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      clear_state();
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) version_bits = cfg_data;
      if (push && !full)
        expected_results.push_back(mmu_step(in_mode, in_reg_index, in_write_data,
                                            in_dvma_address, in_access_is_write,
                                            in_pte_word));
      if (pop && !empty) begin
        got.read_data     = out_read_data;
        got.pte_address   = out_pte_address;
        got.phys_address  = out_phys_address;
        got.page_address  = out_page_address;
        got.permission    = out_permission;
        got.fault         = out_fault;
        got.interrupt_out = out_interrupt_out;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, got %p", $time, got);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("read_data", 36'(want.read_data), 36'(got.read_data));
          check_field("pte_address", 36'(want.pte_address), 36'(got.pte_address));
          check_field("phys_address", want.phys_address, got.phys_address);
          check_field("page_address", 36'(want.page_address), 36'(got.page_address));
          check_field("permission", 36'(want.permission), 36'(got.permission));
          check_field("fault", 36'(want.fault), 36'(got.fault));
          check_field("interrupt_out", 36'(want.interrupt_out),
                      36'(got.interrupt_out));
        end
      end
    end
    pending_count = expected_results.size();
  end

endmodule

@@ tb/io_mmu_register_and_translate_test.sv @@
// io_mmu_register_and_translate_test: clock, reset and stimulus for the I/O MMU
// register and translate block; checking lives in iomt_xlate_monitor.
// Depends on iomt_pkg, io_mmu_register_and_translate and iomt_xlate_monitor.
`timescale 1ns / 100ps

module io_mmu_register_and_translate_test;
  import iomt_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [31:0]      cfg_data;
  logic             push;
  logic             full;
  logic [1:0]       in_mode;
  logic [IDX_W-1:0] in_reg_index;
  logic [31:0]      in_write_data;
  logic [31:0]      in_dvma_address;
  logic             in_access_is_write;
  logic [31:0]      in_pte_word;
  logic             empty;
  logic             pop;
  logic [31:0]      out_read_data;
  logic [31:0]      out_pte_address;
  logic [35:0]      out_phys_address;
  logic [31:0]      out_page_address;
  logic [1:0]       out_permission;
  logic             out_fault;
  logic             out_interrupt_out;

  int n_sent = 0;
  int n_got  = 0;
  bit calm   = 1'b0;
  int fail_count;
  int pending_count;

  always #5 clk = ~clk;

  io_mmu_register_and_translate dut (.*);

  iomt_xlate_monitor mon (.*);

  // run limit
  initial begin
    #(2_000_000);
    $display("[io_mmu_register_and_translate] ERROR");
    $finish;
  end

  // count result transactions taken
  always @(posedge clk) begin
    if (rst_n && pop && !empty) n_got <= n_got + 1;
  end

  // result side: random pops, with a long hold-off now and then
  initial begin
    int hold_at = 150;
    pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (n_got >= hold_at) begin
        pop <= 1'b0;
        hold_at += 450;
        repeat (80) @(negedge clk);
      end
      pop <= calm || ($urandom_range(99) >= 36);
    end
  end

  // config write, called at a falling edge while the block is idle
  task automatic set_version(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // offer one transaction with random idle cycles ahead of it
  task automatic issue(input logic [1:0] m, input logic [IDX_W-1:0] ix,
                       input logic [31:0] wd, input logic [31:0] dv,
                       input logic wr, input logic [31:0] pte);
    while (!calm && $urandom_range(99) < 36) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push               <= 1'b1;
    in_mode            <= m;
    in_reg_index       <= ix;
    in_write_data      <= wd;
    in_dvma_address    <= dv;
    in_access_is_write <= wr;
    in_pte_word        <= pte;
    @(posedge clk);
    while (full) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  // stop offering until every result is back
  task automatic settle();
    push <= 1'b0;
    wait (n_got == n_sent);
    @(negedge clk);
  endtask

  // half named registers, half anywhere in the store
  function automatic logic [IDX_W-1:0] pick_index();
    logic [IDX_W-1:0] named [12] = '{IX_CTRL, IX_BASE, IX_FSR, IX_FAR, IX_AER,
                                     IX_AER + IDX_W'(1), IX_SBC0,
                                     IX_SBC0 + IDX_W'(1), IX_SBC0 + IDX_W'(2),
                                     IX_SBC3, IX_ARBEN, IX_MASKID};
    if ($urandom_range(1)) return named[$urandom_range(11)];
    return IDX_W'($urandom);
  endfunction

  task automatic random_item();
    int               kind;
    logic [31:0]      pte;
    logic [IDX_W-1:0] ix;
    kind = $urandom_range(99);
    pte  = $urandom;
    ix   = pick_index();
    if (kind < 45) begin
      // mostly valid entries so that translations get through
      if ($urandom_range(9) < 7) pte[1] = 1'b1;
      issue(OP_XLATE, ix, $urandom, $urandom, 1'($urandom_range(1)), pte);
    end else if (kind < 65) begin
      issue(OP_WRITE, ix, $urandom, $urandom, 1'($urandom_range(1)), pte);
    end else if (kind < 95) begin
      issue(OP_READ, ix, $urandom, $urandom, 1'($urandom_range(1)), pte);
    end else begin
      issue(OP_NONE, ix, $urandom, $urandom, 1'($urandom_range(1)), pte);
    end
  endtask

  // stimulus
  initial begin
    logic [31:0] versions [4];
    push               = 1'b0;
    cfg_valid          = 1'b0;
    cfg_data           = '0;
    in_mode            = OP_READ;
    in_reg_index       = '0;
    in_write_data      = '0;
    in_dvma_address    = '0;
    in_access_is_write = 1'b0;
    in_pte_word        = '0;
    versions = '{32'h0, $urandom, $urandom, 32'hffffffff};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_version(32'hffffffff);

    // reset values
    issue(OP_READ, IX_CTRL, $urandom, $urandom, 1'b0, $urandom);
    issue(OP_READ, IX_FSR, $urandom, $urandom, 1'b1, $urandom);
    issue(OP_READ, IX_AER, $urandom, $urandom, 1'b0, $urandom);
    issue(OP_READ, IX_ARBEN, $urandom, $urandom, 1'b0, $urandom);
    issue(OP_READ, IX_MASKID, $urandom, $urandom, 1'b0, $urandom);
    // control write picks up version bits and the widest window
    issue(OP_WRITE, IX_CTRL, 32'hffffffff, $urandom, 1'b0, $urandom);
    issue(OP_READ, IX_CTRL, $urandom, $urandom, 1'b0, $urandom);
    issue(OP_WRITE, IX_BASE, 32'hffffffff, $urandom, 1'b0, $urandom);
    issue(OP_WRITE, IX_CTRL, 32'h0, $urandom, 1'b0, $urandom);
    // good translations, read-write and read-only
    issue(OP_XLATE, IDX_W'($urandom), $urandom, 32'hffffffff, 1'b1, 32'hffffffff);
    issue(OP_XLATE, IDX_W'($urandom), $urandom, 32'h0, 1'b0, 32'h00000002);
    // write to a read-only page faults, reading the fault address clears it
    issue(OP_XLATE, IDX_W'($urandom), $urandom, $urandom, 1'b1, 32'h00000002);
    issue(OP_READ, IX_FAR, $urandom, $urandom, 1'b0, $urandom);
    // invalid entry on a read, then cleared by writes to the fault registers
    issue(OP_XLATE, IDX_W'($urandom), $urandom, $urandom, 1'b0, 32'hfffffffd);
    issue(OP_READ, IX_FSR, $urandom, $urandom, 1'b0, $urandom);
    issue(OP_WRITE, IX_FAR, 32'h0, $urandom, 1'b0, $urandom);
    issue(OP_XLATE, IDX_W'($urandom), $urandom, $urandom, 1'b1, 32'h0);
    issue(OP_WRITE, IX_FSR, 32'hffffffff, $urandom, 1'b0, $urandom);
    // masked registers and a plain one
    issue(OP_WRITE, IX_AER, 32'h0, $urandom, 1'b0, $urandom);
    issue(OP_WRITE, IX_SBC0, 32'hffffffff, $urandom, 1'b0, $urandom);
    issue(OP_WRITE, IX_SBC3, 32'hffffffff, $urandom, 1'b0, $urandom);
    issue(OP_WRITE, IX_ARBEN, 32'hffffffff, $urandom, 1'b0, $urandom);
    issue(OP_WRITE, IX_MASKID, 32'h00ffffff, $urandom, 1'b0, $urandom);
    issue(OP_WRITE, '1, 32'hffffffff, $urandom, 1'b0, $urandom);
    issue(OP_READ, '1, $urandom, $urandom, 1'b0, $urandom);
    // unused mode does nothing
    issue(OP_NONE, '1, 32'hffffffff, 32'hffffffff, 1'b1, 32'hffffffff);
    settle();

    // random phases, each under its own version bits
    for (int p = 0; p < 4; p++) begin
      set_version(versions[p]);
      calm = (p == 2);
      for (int k = 0; k < 225; k++) begin
        if (p == 1 && k == 100) settle();
        random_item();
      end
      settle();
    end
    calm = 1'b0;

    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[io_mmu_register_and_translate] OK");
    end else begin
      $display("[io_mmu_register_and_translate] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/iomt_pkg.sv
design/iomt_ram.sv
design/iomt_fifo.sv
design/iomt_front.sv
design/iomt_back.sv
design/io_mmu_register_and_translate.sv
tb/iomt_xlate_monitor.sv
tb/io_mmu_register_and_translate_test.sv
